>>> sv/sdlr_pkg.sv
`timescale 1ns / 1ps
package sdlr_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int RATE_W      = 18;
    localparam int CNT_W       = 32;
    localparam int KRO_W       = CNT_W + RATE_W;
    localparam int OIS_W       = 56;
    localparam int CMP_W       = OIS_W + 2;

    // register indices
    localparam logic [1:0] CFG_IN_RATE  = 2'd0;
    localparam logic [1:0] CFG_OUT_RATE = 2'd1;
    localparam logic [1:0] CFG_MIX      = 2'd2;
    localparam logic [1:0] CFG_CHANNELS = 2'd3;

    // mix modes
    localparam logic [1:0] MIX_MEAN  = 2'd0;
    localparam logic [1:0] MIX_LEFT  = 2'd1;
    localparam logic [1:0] MIX_RIGHT = 2'd2;

    localparam logic [1:0] CH_MONO = 2'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
        logic                          last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mono_out;
        logic                          last_out;
        logic                          ratio_error;
    } t_out_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x;
        logic                          last;
    } t_mono_item;

    typedef struct packed {
        logic [RATE_W-1:0] in_rate;
        logic [RATE_W-1:0] out_rate;
        logic [1:0]        mix_mode;
        logic [1:0]        channel_count;
    } t_cfg;

endpackage

>>> sv/sdlr_front.sv
`timescale 1ns / 1ps
module sdlr_front
    import sdlr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_q_valid,
    input  logic       i_q_pop,
    output t_mono_item o_q_item
);

    t_mono_item            r_mem [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_fill;
    logic signed [SAMPLE_BITS:0]   w_sum;
    logic signed [SAMPLE_BITS-1:0] w_x;
    logic                  w_push, w_pop;

    // downmix
    always_comb begin
        w_sum = (SAMPLE_BITS+1)'(i_item.left_sample)
                + (SAMPLE_BITS+1)'(i_item.right_sample);
        if (i_cfg.channel_count == CH_MONO || i_cfg.mix_mode == MIX_LEFT) begin
            w_x = i_item.left_sample;
        end else if (i_cfg.mix_mode == MIX_RIGHT) begin
            w_x = i_item.right_sample;
        end else begin
            w_x = w_sum[SAMPLE_BITS:1];
        end
    end

    assign o_stall   = (r_fill == 2'd2);
    assign w_push    = i_valid && !o_stall;
    assign o_q_valid = (r_fill != 2'd0);
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    // two-entry queue to the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_fill <= r_fill + 2'(w_push) - 2'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp].x    <= w_x;
            r_mem[r_wp].last <= i_item.last_in;
        end
    end

endmodule

>>> sv/sdlr_div.sv
`timescale 1ns / 1ps
module sdlr_div
    import sdlr_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RATE_W-1:0]    i_rem,
    input  logic [RATE_W-1:0]    i_div,
    output logic                 o_done,
    output logic [FRAC_BITS-1:0] o_quot
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [RATE_W:0]   r_r;
    logic [RATE_W-1:0] r_d;
    logic [FRAC_BITS-1:0] r_q;
    logic [RATE_W:0]   w_t;
    logic              w_ge;

    assign w_t    = {r_r[RATE_W-1:0], 1'b0};
    assign w_ge   = (w_t >= {1'b0, r_d});
    assign o_done = r_busy && (r_cnt == CW'(0));
    assign o_quot = r_q;

    // restoring division, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= CW'(0);
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(FRAC_BITS);
        end else if (r_busy) begin
            if (r_cnt == CW'(0)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_start) begin
            r_r <= {1'b0, i_rem};
            r_d <= i_div;
            r_q <= '0;
        end else if (r_busy && r_cnt != CW'(0)) begin
            r_r <= w_ge ? (w_t - {1'b0, r_d}) : w_t;
            r_q <= {r_q[FRAC_BITS-2:0], w_ge};
        end
    end

endmodule

>>> sv/sdlr_back.sv
`timescale 1ns / 1ps
module sdlr_back
    import sdlr_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_UPSAMPLE = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_clear,
    input  logic       i_q_valid,
    output logic       o_q_pop,
    input  t_mono_item i_q_item,
    output logic       o_valid,
    input  logic       i_stall,
    output t_out_item  o_item
);

    localparam int MU_W = $clog2(MAX_UPSAMPLE + 1);
    localparam int PW   = RATE_W + MU_W;
    localparam int TW   = SAMPLE_BITS + FRAC_BITS + 2;

    typedef enum logic [3:0] {
        S_IDLE, S_CLASS, S_LOOP, S_DIV, S_MUL, S_SUM,
        S_FLUSH, S_AFTER, S_TAIL, S_FIN0, S_FIN1
    } t_state;

    t_state r_state;
    logic signed [SAMPLE_BITS-1:0] r_prev, r_x, r_v, r_hv, r_sv;
    logic [CNT_W-1:0] r_cnt;
    logic [KRO_W-1:0] r_kro, r_cro;
    logic [OIS_W-1:0] r_ois;
    logic r_hvl, r_svl, r_any, r_last, r_tail, r_e1;
    logic [FRAC_BITS-1:0] r_f;
    logic signed [TW-1:0] r_prod;
    logic      r_ov;
    t_out_item r_oitem;

    logic [RATE_W-1:0] w_ri, w_ro, w_rem;
    logic [PW-1:0]     w_mri;
    logic w_err, w_eq, w_free, w_sat, w_rel, w_e0, w_tail_go, w_div_start, w_div_done;
    logic [KRO_W-1:0] w_cro, w_base;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [OIS_W-1:0] w_qri, w_hs, w_remf;
    logic [CMP_W-1:0] w_ri3, w_cro2, w_hs2;
    logic [FRAC_BITS-1:0] w_quot;
    logic signed [TW-1:0] w_t;

    // effective rates and frame class
    assign w_ri   = (i_cfg.in_rate  == '0) ? RATE_W'(1) : i_cfg.in_rate;
    assign w_ro   = (i_cfg.out_rate == '0) ? RATE_W'(1) : i_cfg.out_rate;
    assign w_mri  = PW'(w_ri) * PW'(MAX_UPSAMPLE);
    assign w_err  = (PW'(w_ro) > w_mri);
    assign w_eq   = (w_ri == w_ro);
    assign w_free = !r_ov || !i_stall;

    assign w_sat     = (r_cnt == '1);
    assign w_cnt_inc = w_sat ? r_cnt : r_cnt + CNT_W'(1);
    assign w_cro     = w_sat ? r_kro : r_kro + KRO_W'(w_ro);

    // position of the queue head, and its release test
    always_comb begin
        case ({r_svl, r_hvl})
            2'b11:   w_qri = OIS_W'({w_ri, 1'b0});
            2'b01,
            2'b10:   w_qri = OIS_W'(w_ri);
            default: w_qri = '0;
        endcase
    end
    assign w_hs   = r_ois - w_qri;
    assign w_hs2  = CMP_W'({w_hs, 1'b0});
    assign w_ri3  = CMP_W'(w_ri) + CMP_W'({w_ri, 1'b0});
    assign w_cro2 = CMP_W'({r_cro, 1'b0});
    assign w_rel  = (w_hs2 + w_ri3 <= w_cro2);
    assign w_e0   = r_hvl && (w_hs == '0 || w_hs2 + CMP_W'(w_ri) <= w_cro2);
    assign w_tail_go = !r_any ||
                       (CMP_W'({r_ois, 1'b0}) + CMP_W'(w_ri) <= w_cro2);

    // interpolation remainder
    assign w_base = r_kro - KRO_W'(w_ro);
    assign w_remf = (r_ois >= OIS_W'(w_base)) ? r_ois - OIS_W'(w_base) : '0;
    assign w_rem  = w_remf[RATE_W-1:0];
    assign w_div_start = (r_state == S_LOOP) && (r_cnt != '0) &&
                         (OIS_W'(r_kro) > r_ois);

    sdlr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_rem),
        .i_div   (w_ro),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign w_t = (TW'(r_prev) <<< FRAC_BITS) + r_prod + (TW'(1) <<< (FRAC_BITS - 1));

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_ov;
    assign o_item  = r_oitem;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_prev  <= '0;
            r_cnt   <= '0;
            r_kro   <= '0;
            r_ois   <= '0;
            r_hvl   <= 1'b0;
            r_svl   <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            if (!i_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_clear) begin
                        r_prev <= '0;
                        r_cnt  <= '0;
                        r_kro  <= '0;
                        r_ois  <= '0;
                        r_hvl  <= 1'b0;
                        r_svl  <= 1'b0;
                        r_any  <= 1'b0;
                    end else if (i_q_valid) begin
                        r_x     <= i_q_item.x;
                        r_last  <= i_q_item.last;
                        r_state <= S_CLASS;
                    end
                end
                S_CLASS: begin
                    r_cro <= w_cro;
                    if (w_err || w_eq) begin
                        if (w_free) begin
                            r_ov                <= 1'b1;
                            r_oitem.mono_out    <= w_err ? '0 : r_x;
                            r_oitem.last_out    <= r_last;
                            r_oitem.ratio_error <= w_err;
                            if (r_last) begin
                                r_prev <= '0;
                                r_cnt  <= '0;
                                r_kro  <= '0;
                                r_ois  <= '0;
                                r_hvl  <= 1'b0;
                                r_svl  <= 1'b0;
                                r_any  <= 1'b0;
                            end else if (!w_err) begin
                                r_prev <= r_x;
                                r_cnt  <= w_cnt_inc;
                                r_kro  <= w_cro;
                            end
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_LOOP;
                    end
                end
                S_LOOP: begin
                    r_state <= w_div_start ? S_DIV : S_AFTER;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_f     <= w_quot;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= TW'((SAMPLE_BITS+1)'(r_x) - (SAMPLE_BITS+1)'(r_prev))
                               * TW'({1'b0, r_f});
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_v     <= w_t[FRAC_BITS +: SAMPLE_BITS];
                    r_tail  <= 1'b0;
                    r_state <= S_FLUSH;
                end
                // release ready outputs, then add one computed output to the hold queue, emitting the head when full
                S_FLUSH: begin
                    if (r_hvl && w_rel) begin
                        if (w_free) begin
                            r_ov    <= 1'b1;
                            r_oitem <= '{mono_out: r_hv, last_out: 1'b0, ratio_error: 1'b0};
                            r_hv    <= r_sv;
                            r_hvl   <= r_svl;
                            r_svl   <= 1'b0;
                        end
                    end else if (r_svl) begin
                        if (w_free) begin
                            r_ov    <= 1'b1;
                            r_oitem <= '{mono_out: r_hv, last_out: 1'b0, ratio_error: 1'b0};
                            r_hv    <= r_sv;
                            r_sv    <= r_v;
                            r_ois   <= r_ois + OIS_W'(w_ri);
                            r_any   <= 1'b1;
                            r_state <= r_tail ? S_TAIL : S_LOOP;
                        end
                    end else begin
                        if (r_hvl) begin
                            r_sv  <= r_v;
                            r_svl <= 1'b1;
                        end else begin
                            r_hv  <= r_v;
                            r_hvl <= 1'b1;
                        end
                        r_ois   <= r_ois + OIS_W'(w_ri);
                        r_any   <= 1'b1;
                        r_state <= r_tail ? S_TAIL : S_LOOP;
                    end
                end
                S_AFTER: begin
                    if (r_last) begin
                        r_state <= S_TAIL;
                    end else if (r_hvl && w_rel) begin
                        if (w_free) begin
                            r_ov    <= 1'b1;
                            r_oitem <= '{mono_out: r_hv, last_out: 1'b0, ratio_error: 1'b0};
                            r_hv    <= r_sv;
                            r_hvl   <= r_svl;
                            r_svl   <= 1'b0;
                        end
                    end else begin
                        r_prev  <= r_x;
                        r_cnt   <= w_cnt_inc;
                        r_kro   <= r_cro;
                        r_state <= S_IDLE;
                    end
                end
                // tail outputs repeat the last sample
                S_TAIL: begin
                    if (w_tail_go) begin
                        r_v     <= r_x;
                        r_tail  <= 1'b1;
                        r_state <= S_FLUSH;
                    end else begin
                        r_state <= S_FIN0;
                    end
                end
                S_FIN0: begin
                    if (w_e0) begin
                        if (w_free) begin
                            r_ov    <= 1'b1;
                            r_oitem <= '{mono_out: r_hv, last_out: !(r_svl && w_rel),
                                         ratio_error: 1'b0};
                            r_e1    <= r_svl && w_rel;
                            r_state <= S_FIN1;
                        end
                    end else begin
                        r_e1    <= r_svl && w_rel;
                        r_state <= S_FIN1;
                    end
                end
                S_FIN1: begin
                    if (!r_e1 || w_free) begin
                        if (r_e1) begin
                            r_ov    <= 1'b1;
                            r_oitem <= '{mono_out: r_sv, last_out: 1'b1, ratio_error: 1'b0};
                        end
                        r_prev  <= '0;
                        r_cnt   <= '0;
                        r_kro   <= '0;
                        r_ois   <= '0;
                        r_hvl   <= 1'b0;
                        r_svl   <= 1'b0;
                        r_any   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> sv/stereo_downmix_linear_resampler_top.sv
`timescale 1ns / 1ps
// An accepted frame is written into the front queue; the back end takes it when
// idle, and a pass-through or ratio-error result is registered in S_CLASS. Each
// interpolated output passes S_LOOP, S_DIV (serial fraction divider), S_MUL,
// S_SUM and S_FLUSH, each tail output S_TAIL and S_FLUSH, waiting while stalled.
// The back end handles one frame at a time, with two frames queued in front.
// Reset: synchronous active-low; registers return to 44100 Hz, mean, stereo.
module stereo_downmix_linear_resampler_top
    import sdlr_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int MAX_UPSAMPLE = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [RATE_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_clear;
    logic       w_wr, w_q_valid, w_q_pop;
    t_mono_item w_q_item;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid && o_cfg_ready;

    // configuration registers; a rate write clears the stream state if the back end is idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_rate       <= RATE_W'(44100);
            r_cfg.out_rate      <= RATE_W'(44100);
            r_cfg.mix_mode      <= MIX_MEAN;
            r_cfg.channel_count <= 2'd2;
            r_clear             <= 1'b0;
        end else begin
            r_clear <= 1'b0;
            if (w_wr) begin
                unique case (i_cfg_index)
                    CFG_IN_RATE: begin
                        r_cfg.in_rate <= i_cfg_data;
                        r_clear       <= 1'b1;
                    end
                    CFG_OUT_RATE: begin
                        r_cfg.out_rate <= i_cfg_data;
                        r_clear        <= 1'b1;
                    end
                    CFG_MIX:      r_cfg.mix_mode      <= i_cfg_data[1:0];
                    CFG_CHANNELS: r_cfg.channel_count <= i_cfg_data[1:0];
                    default:      r_clear             <= 1'b0;
                endcase
            end
        end
    end

    sdlr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_item    (i_in_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_item  (w_q_item)
    );

    sdlr_back #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_clear   (r_clear),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_item  (w_q_item),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_item    (o_out_item)
    );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sdlr_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_UPSAMPLE = 16;
    localparam int RESULT_CAP   = 40;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_item;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_item;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [RATE_W-1:0] i_cfg_data;

    stereo_downmix_linear_resampler_top #(
        .FRAC_BITS(FRAC_BITS),
        .MAX_UPSAMPLE(MAX_UPSAMPLE)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // predictor copy of the registers and stream state
    logic [RATE_W-1:0]  m_in_rate, m_out_rate;
    logic [1:0]         m_mix, m_chans;
    longint             m_prev;
    longint unsigned    m_count;
    longint unsigned    m_pos;
    longint             m_head, m_second;
    bit                 m_head_ok, m_second_ok, m_started;

    t_out_item          pending_mono[$];
    t_out_item          batch[$];
    int                 errors;
    int                 n_results;
    int                 n_frames;
    int                 n_streams;
    bit                 hold_receiver;

    function automatic t_out_item mk(longint v, bit lst, bit err);
        t_out_item o;
        o.mono_out    = v[SAMPLE_BITS-1:0];
        o.last_out    = lst;
        o.ratio_error = err;
        return o;
    endfunction

    function automatic void push_result(longint v, bit lst, bit err);
        if (batch.size() < RESULT_CAP) batch.push_back(mk(v, lst, err));
    endfunction

    function automatic void clear_stream();
        m_prev = 0; m_count = 0; m_pos = 0;
        m_head = 0; m_second = 0;
        m_head_ok = 0; m_second_ok = 0; m_started = 0;
    endfunction

    function automatic longint floor_half(longint t, int s);
        return t >>> s;
    endfunction

    function automatic void pop_head();
        m_head = m_second; m_head_ok = m_second_ok;
        m_second_ok = 0; m_second = 0;
    endfunction

    function automatic longint unsigned head_pos(longint unsigned ri);
        return m_pos - (longint'(m_head_ok) + longint'(m_second_ok)) * ri;
    endfunction

    // release queued outputs whose successor is known to exist
    function automatic void release_ready(longint unsigned ri, ro, cnt);
        longint unsigned succ;
        while (m_head_ok) begin
            succ = head_pos(ri) + ri;
            if (2 * succ + ri > 2 * cnt * ro) break;
            push_result(m_head, 0, 0);
            pop_head();
        end
    endfunction

    function automatic void queue_output(longint v, longint unsigned ri, ro, cnt);
        release_ready(ri, ro, cnt);
        if (m_second_ok) begin
            push_result(m_head, 0, 0);
            pop_head();
        end
        if (!m_head_ok) begin
            m_head = v; m_head_ok = 1;
        end else begin
            m_second = v; m_second_ok = 1;
        end
        m_pos += ri;
        m_started = 1;
    endfunction

    function automatic longint lerp(longint a, b, longint unsigned rem, ro);
        longint unsigned one, f;
        one = 64'd1 << FRAC_BITS;
        f = (rem << FRAC_BITS) / ro;
        if (f > one - 1) f = one - 1;
        return floor_half(a * longint'(one) + (b - a) * longint'(f)
                          + longint'(one >> 1), FRAC_BITS);
    endfunction

    // work out the results of one frame into batch
    function automatic void predict_frame(t_in_item it);
        longint unsigned ri, ro, k, cnt, base, lim, rem, hs;
        longint l, r, x;
        bit e0, e1;
        batch.delete();
        ri = (m_in_rate == 0) ? 1 : m_in_rate;
        ro = (m_out_rate == 0) ? 1 : m_out_rate;
        l = longint'(it.left_sample);
        r = longint'(it.right_sample);
        if (m_chans == CH_MONO || m_mix == MIX_LEFT) x = l;
        else if (m_mix == MIX_RIGHT) x = r;
        else x = floor_half(l + r, 1);

        if (ro > MAX_UPSAMPLE * ri) begin
            push_result(0, it.last_in, 1);
            if (it.last_in) clear_stream();
            return;
        end
        k = m_count;
        cnt = (m_count == 64'hFFFF_FFFF) ? k : k + 1;
        if (ri == ro) begin
            push_result(x, it.last_in, 0);
            if (it.last_in) clear_stream();
            else begin
                m_prev = x; m_count = cnt;
            end
            return;
        end
        if (k >= 1) begin
            base = (k - 1) * ro;
            lim = k * ro;
            while (m_pos < lim) begin
                rem = (m_pos >= base) ? m_pos - base : 0;
                queue_output(lerp(m_prev, x, rem, ro), ri, ro, cnt);
            end
        end
        if (!it.last_in) begin
            release_ready(ri, ro, cnt);
            m_prev = x; m_count = cnt;
            return;
        end
        // tail repeats the final sample
        while (!m_started || 2 * m_pos + ri <= 2 * cnt * ro)
            queue_output(x, ri, ro, cnt);
        hs = head_pos(ri);
        e0 = m_head_ok && (hs == 0 || 2 * hs + ri <= 2 * cnt * ro);
        e1 = m_second_ok && (2 * (hs + ri) + ri <= 2 * cnt * ro);
        if (e0) push_result(m_head, e1 ? 1'b0 : 1'b1, 0);
        if (e1) push_result(m_second, 1, 0);
        clear_stream();
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_mono.size() == 0) begin
                $error("unexpected item: mono_out %0d", o_out_item.mono_out);
                errors++;
            end else begin
                exp_item = pending_mono.pop_front();
                if (o_out_item.mono_out !== exp_item.mono_out) begin
                    $error("mono_out expected %0d actual %0d",
                           exp_item.mono_out, o_out_item.mono_out);
                    errors++;
                end
                if (o_out_item.last_out !== exp_item.last_out) begin
                    $error("last_out expected %0b actual %0b",
                           exp_item.last_out, o_out_item.last_out);
                    errors++;
                end
                if (o_out_item.ratio_error !== exp_item.ratio_error) begin
                    $error("ratio_error expected %0b actual %0b",
                           exp_item.ratio_error, o_out_item.ratio_error);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern, with a long hold-off when asked
    initial begin
        int mode_len;
        int stall_pct;
        i_out_stall <= 1'b0;
        forever begin
            mode_len  = $urandom_range(10, 80);
            stall_pct = $urandom_range(0, 3) * 25;
            repeat (mode_len) begin
                @(posedge i_clk);
                if (hold_receiver) i_out_stall <= 1'b1;
                else i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // overall limit
    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_reg(logic [1:0] idx, logic [RATE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_IN_RATE:  begin m_in_rate = val; clear_stream(); end
            CFG_OUT_RATE: begin m_out_rate = val; clear_stream(); end
            CFG_MIX:      m_mix = val[1:0];
            default:      m_chans = val[1:0];
        endcase
    endtask

    // wait until every expected item is in, then let the block settle long
    // enough to finish any held outputs of an unterminated stream
    task automatic drain();
        int guard;
        guard = 0;
        while (pending_mono.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (1000) @(posedge i_clk);
    endtask

    // send one frame, with the expectation queued at acceptance
    task automatic send_frame(t_in_item it, bit chk_typed, t_out_item typed);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_frame(it);
        if (chk_typed && (batch.size() != 1 || batch[0] !== typed)) begin
            $error("predictor row mismatch: mono_out expected %0d", typed.mono_out);
            errors++;
        end
        foreach (batch[i]) pending_mono.push_back(batch[i]);
        n_frames++;
        if (it.last_in) n_streams++;
    endtask

    // random gap between bursts; valid is lowered only when a gap is taken
    task automatic maybe_gap(ref int burst);
        if (burst > 0) begin
            burst--;
            return;
        end
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge i_clk);
        burst = $urandom_range(0, 20);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rnd_sample();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    typedef struct {
        logic [RATE_W-1:0] ri, ro;
        logic [1:0]        mix, ch;
        t_in_item          it;
        bit                typed;
        t_out_item         res;
    } t_row;

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = 24'sh800000;

    t_row rows[] = '{
        // equal rates from reset: each mix mode and channel count passes straight through
        '{44100, 44100, MIX_MEAN, 2, '{24'sd100, 24'sd300, 1'b0}, 1, '{24'sd200, 0, 0}},
        '{44100, 44100, MIX_MEAN, 2, '{SMAX, SMAX, 1'b0}, 1, '{SMAX, 0, 0}},
        '{44100, 44100, MIX_MEAN, 2, '{SMIN, SMIN, 1'b0}, 1, '{SMIN, 0, 0}},
        '{44100, 44100, MIX_MEAN, 2, '{-24'sd1, 24'sd0, 1'b1}, 1, '{-24'sd1, 1, 0}},
        '{44100, 44100, MIX_LEFT, 2, '{SMAX, SMIN, 1'b0}, 1, '{SMAX, 0, 0}},
        '{44100, 44100, MIX_RIGHT, 2, '{SMAX, SMIN, 1'b0}, 1, '{SMIN, 0, 0}},
        '{44100, 44100, 2'd3, 2, '{SMAX, SMIN, 1'b0}, 1, '{-24'sd1, 0, 0}},
        '{44100, 44100, MIX_RIGHT, 1, '{24'sd5, 24'sd9, 1'b0}, 1, '{24'sd5, 0, 0}},
        '{44100, 44100, MIX_RIGHT, 0, '{24'sd5, 24'sd9, 1'b1}, 1, '{24'sd9, 1, 0}},
        // ratio too high, both rates at their extremes, zero rate as one
        '{1, 192000, MIX_MEAN, 2, '{SMAX, SMAX, 1'b0}, 1, '{24'sd0, 0, 1}},
        '{1, 192000, MIX_MEAN, 2, '{SMAX, SMAX, 1'b1}, 1, '{24'sd0, 1, 1}},
        '{0, 17, MIX_MEAN, 2, '{24'sd7, 24'sd7, 1'b1}, 1, '{24'sd0, 1, 1}},
        '{0, 0, MIX_LEFT, 2, '{24'sd7, 24'sd1, 1'b1}, 1, '{24'sd7, 1, 0}},
        // single frame stream, one output
        '{192000, 1, MIX_LEFT, 2, '{SMIN, 24'sd0, 1'b1}, 1, '{SMIN, 1, 0}},
        // upsample and downsample, predictor checked
        '{1, 16, MIX_MEAN, 2, '{SMAX, SMIN, 1'b0}, 0, '{0, 0, 0}},
        '{1, 16, MIX_MEAN, 2, '{SMIN, SMAX, 1'b0}, 0, '{0, 0, 0}},
        '{1, 16, MIX_MEAN, 2, '{SMAX, SMAX, 1'b1}, 0, '{0, 0, 0}},
        '{48000, 44100, MIX_LEFT, 2, '{SMAX, 24'sd0, 1'b0}, 0, '{0, 0, 0}},
        '{48000, 44100, MIX_LEFT, 2, '{SMIN, 24'sd0, 1'b0}, 0, '{0, 0, 0}},
        '{48000, 44100, MIX_LEFT, 2, '{24'sd3, 24'sd0, 1'b1}, 0, '{0, 0, 0}},
        '{3, 7, MIX_RIGHT, 2, '{24'sd0, 24'sd1000, 1'b0}, 0, '{0, 0, 0}},
        '{3, 7, MIX_RIGHT, 2, '{24'sd0, -24'sd1000, 1'b1}, 0, '{0, 0, 0}}
    };

    // rate pairs for the random part
    logic [RATE_W-1:0] rate_sets[8][2] = '{
        '{44100, 48000}, '{48000, 44100}, '{8000, 96000}, '{192000, 8000},
        '{1, 16}, '{5, 3}, '{22050, 22050}, '{1, 17}
    };

    // main stimulus
    initial begin
        t_in_item it;
        t_out_item none;
        int burst;
        int sel;
        int len;
        int sent;
        errors = 0; n_results = 0; n_frames = 0; n_streams = 0;
        hold_receiver = 0;
        burst = 0;
        none = '0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_item   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IN_RATE;
        i_cfg_data  <= '0;
        m_in_rate = 44100; m_out_rate = 44100; m_mix = MIX_MEAN; m_chans = 2;
        clear_stream();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (300) @(posedge i_clk);

        // directed table; registers rewritten only when a row changes them
        foreach (rows[i]) begin
            if (i == 0 || rows[i].ri != m_in_rate || rows[i].ro != m_out_rate
                || rows[i].mix != m_mix || rows[i].ch != m_chans) begin
                i_in_valid <= 1'b0;
                drain();
                if (i != 0) begin
                    if (rows[i].ri != m_in_rate) write_reg(CFG_IN_RATE, rows[i].ri);
                    if (rows[i].ro != m_out_rate) write_reg(CFG_OUT_RATE, rows[i].ro);
                    if (rows[i].mix != m_mix)
                        write_reg(CFG_MIX, RATE_W'(rows[i].mix));
                    if (rows[i].ch != m_chans)
                        write_reg(CFG_CHANNELS, RATE_W'(rows[i].ch));
                end
            end
            send_frame(rows[i].it, rows[i].typed, rows[i].res);
        end
        i_in_valid <= 1'b0;
        drain();

        // random streams, mostly well terminated
        sent = 0;
        while (sent < 400) begin
            sel = $urandom_range(0, 7);
            write_reg(CFG_IN_RATE, rate_sets[sel][0]);
            write_reg(CFG_OUT_RATE, rate_sets[sel][1]);
            write_reg(CFG_MIX, RATE_W'($urandom_range(0, 3)));
            write_reg(CFG_CHANNELS, RATE_W'($urandom_range(0, 3)));
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 8);
            // long receiver hold-off while a long stream keeps coming
            if (sent == 0) begin
                len = 40;
                hold_receiver = 1;
                fork
                    begin
                        repeat (3000) @(posedge i_clk);
                        hold_receiver = 0;
                    end
                join_none
            end
            for (int j = 0; j < len; j++) begin
                it.left_sample  = rnd_sample();
                it.right_sample = rnd_sample();
                it.last_in      = (j == len - 1) && ($urandom_range(0, 7) != 0);
                send_frame(it, 0, none);
                sent++;
                maybe_gap(burst);
            end
            // sender waits for everything before reconfiguring
            i_in_valid <= 1'b0;
            drain();
        end

        $display("ran %0d frames over %0d closed streams, %0d items checked",
                 n_frames, n_streams, n_results);
        $display("rates swept from 1 Hz to 192 kHz, all mix modes and channel counts");
        if (errors == 0 && pending_mono.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/sdlr_pkg.sv
sv/sdlr_front.sv
sv/sdlr_div.sv
sv/sdlr_back.sv
sv/stereo_downmix_linear_resampler_top.sv
bench/testbench.sv
